### hdl/tlps_pkg.sv
// ----------------------------------------------------------------------------
// Traffic light pedestrian sequencer package
// Phase encodings, register indexes and widths shared by the sequencer.
// ----------------------------------------------------------------------------
package tlps_pkg;

  localparam int unsigned SEC_W   = 7;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned DRIVE_W = 2;
  localparam int unsigned INDEX_W = 3;

  localparam logic [SEC_W-1:0] ELAPSED_MAX = 7'd127;
  localparam logic [SEC_W-1:0] DISPLAY_MAX = 7'd99;
  localparam logic [SEC_W-1:0] DECIMAL_BASE = 7'd10;

  // Multiplying by 205 and dropping 11 bits divides by ten for values up to 99.
  localparam logic [14:0] DIV10_RECIP = 15'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  typedef enum logic [5:0] {
    PH_RED       = 6'b000001,
    PH_YELLOW    = 6'b000010,
    PH_GREEN     = 6'b000100,
    PH_MOTOR_CW  = 6'b001000,
    PH_CROSS     = 6'b010000,
    PH_MOTOR_ACW = 6'b100000
  } phase_t;

  localparam logic [CODE_W-1:0] CODE_RED       = 3'd0;
  localparam logic [CODE_W-1:0] CODE_YELLOW    = 3'd1;
  localparam logic [CODE_W-1:0] CODE_GREEN     = 3'd2;
  localparam logic [CODE_W-1:0] CODE_MOTOR_CW  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_CROSS     = 3'd4;
  localparam logic [CODE_W-1:0] CODE_MOTOR_ACW = 3'd5;

  localparam logic [DRIVE_W-1:0] DRIVE_STOP = 2'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_CW   = 2'd1;
  localparam logic [DRIVE_W-1:0] DRIVE_ACW  = 2'd2;

  typedef enum logic [INDEX_W-1:0] {
    REG_RED    = 3'd0,
    REG_YELLOW = 3'd1,
    REG_GREEN  = 3'd2,
    REG_MOTOR  = 3'd3,
    REG_WAIT   = 3'd4
  } cfg_reg_t;

endpackage

### hdl/traffic_light_pedestrian_sequencer.sv
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; s_axis_tready stays high while the
// result register is empty or being read in the same cycle.
// Reset (rst, synchronous): red phase, elapsed count zero, delays restored to
// 10/3/10/5/10 seconds, and no result pending.
// ----------------------------------------------------------------------------
// Traffic light pedestrian sequencer
// Six-phase lamp and gate-motor sequencer driven by second ticks and
// pedestrian requests, reporting lamps, motor drive and remaining seconds.
// ----------------------------------------------------------------------------
module traffic_light_pedestrian_sequencer
  import tlps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // second_tick, walk_request, zero fill
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,  // red_lamp, yellow_lamp, green_lamp,
                                                   // motor_drive, tens_digit, ones_digit, phase
  input  logic                      cfg_write,
  input  logic [INDEX_W-1:0]        cfg_index,
  input  logic [SEC_W-1:0]          cfg_data
);

  logic [SEC_W-1:0] red_seconds;
  logic [SEC_W-1:0] yellow_seconds;
  logic [SEC_W-1:0] green_seconds;
  logic [SEC_W-1:0] motor_seconds;
  logic [SEC_W-1:0] wait_seconds;

  phase_t           current_phase;
  phase_t           previous_phase;
  logic [SEC_W-1:0] elapsed_seconds;

  phase_t           current_phase_next;
  phase_t           previous_phase_next;
  logic [SEC_W-1:0] elapsed_seconds_next;
  logic [15:0]      result_next;

  phase_t           ph_start;
  phase_t           ph;
  phase_t           prev_mid;
  logic [SEC_W-1:0] el_mid;
  logic [SEC_W-1:0] delay;
  logic [SEC_W-1:0] remain;
  logic [14:0]      tens_prod;
  logic [DIGIT_W-1:0] tens;
  logic [SEC_W-1:0] ones_full;
  logic [CODE_W-1:0]  code;
  logic [DRIVE_W-1:0] drive;
  logic             lamp_red;
  logic             lamp_yellow;
  logic             lamp_green;
  logic             tick;
  logic             walk;
  logic             accept;
  logic             traffic_phase;

  assign tick          = s_axis_tdata[0];
  assign walk          = s_axis_tdata[1];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (current_phase)
      PH_RED, PH_YELLOW, PH_GREEN, PH_MOTOR_CW, PH_CROSS, PH_MOTOR_ACW: begin
        ph_start = current_phase;
      end
      default: begin
        ph_start = PH_RED;
      end
    endcase

    traffic_phase = (ph_start == PH_RED) || (ph_start == PH_YELLOW) ||
                    (ph_start == PH_GREEN);

    el_mid = (tick && (elapsed_seconds < ELAPSED_MAX)) ? elapsed_seconds + 7'd1
                                                       : elapsed_seconds;
    ph       = ph_start;
    prev_mid = previous_phase;
    if (walk && traffic_phase) begin
      prev_mid = ph_start;
      ph       = PH_MOTOR_CW;
      el_mid   = '0;
    end

    case (ph)
      PH_YELLOW:    delay = yellow_seconds;
      PH_GREEN:     delay = green_seconds;
      PH_MOTOR_CW:  delay = motor_seconds;
      PH_CROSS:     delay = wait_seconds;
      PH_MOTOR_ACW: delay = motor_seconds;
      default:      delay = red_seconds;
    endcase

    remain = (delay > el_mid) ? delay - el_mid : '0;
    if (remain > DISPLAY_MAX) begin
      remain = DISPLAY_MAX;
    end
    tens_prod = {8'd0, remain} * DIV10_RECIP;
    tens      = tens_prod[DIV10_SHIFT +: DIGIT_W];
    ones_full = remain - {3'd0, tens} * DECIMAL_BASE;

    lamp_red    = 1'b1;
    lamp_yellow = 1'b0;
    lamp_green  = 1'b0;
    drive       = DRIVE_STOP;
    case (ph)
      PH_YELLOW: begin
        code        = CODE_YELLOW;
        lamp_red    = 1'b0;
        lamp_yellow = 1'b1;
      end
      PH_GREEN: begin
        code       = CODE_GREEN;
        lamp_red   = 1'b0;
        lamp_green = 1'b1;
      end
      PH_MOTOR_CW: begin
        code  = CODE_MOTOR_CW;
        drive = DRIVE_CW;
      end
      PH_CROSS: begin
        code = CODE_CROSS;
      end
      PH_MOTOR_ACW: begin
        code  = CODE_MOTOR_ACW;
        drive = DRIVE_ACW;
      end
      default: begin
        code = CODE_RED;
      end
    endcase

    result_next = {code, ones_full[DIGIT_W-1:0], tens, drive,
                   lamp_green, lamp_yellow, lamp_red};

    current_phase_next   = ph;
    previous_phase_next  = prev_mid;
    elapsed_seconds_next = el_mid;
    if (el_mid >= delay) begin
      elapsed_seconds_next = '0;
      previous_phase_next  = ph;
      case (ph)
        PH_RED:      current_phase_next = PH_YELLOW;
        PH_GREEN:    current_phase_next = PH_YELLOW;
        PH_YELLOW:   current_phase_next = (prev_mid == PH_RED) ? PH_GREEN : PH_RED;
        PH_MOTOR_CW: current_phase_next = PH_CROSS;
        PH_CROSS:    current_phase_next = PH_MOTOR_ACW;
        default:     current_phase_next = PH_RED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_seconds     <= 7'd10;
      yellow_seconds  <= 7'd3;
      green_seconds   <= 7'd10;
      motor_seconds   <= 7'd5;
      wait_seconds    <= 7'd10;
      current_phase   <= PH_RED;
      previous_phase  <= PH_RED;
      elapsed_seconds <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_RED:    red_seconds    <= cfg_data;
          REG_YELLOW: yellow_seconds <= cfg_data;
          REG_GREEN:  green_seconds  <= cfg_data;
          REG_MOTOR:  motor_seconds  <= cfg_data;
          REG_WAIT:   wait_seconds   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        current_phase   <= current_phase_next;
        previous_phase  <= previous_phase_next;
        elapsed_seconds <= elapsed_seconds_next;
        m_axis_tvalid   <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= result_next;
    end
  end

  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result pending straight after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot(m_axis_tdata[2:0]))
    else $error("not exactly one lamp state in result");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[4:3] != DRIVE_STOP) ==
                       ((m_axis_tdata[15:13] == CODE_MOTOR_CW) ||
                        (m_axis_tdata[15:13] == CODE_MOTOR_ACW))))
    else $error("motor drive does not match phase");

  assert property (@(posedge clk) disable iff (rst)
    (accept && walk && traffic_phase) |=> (m_axis_tdata[15:13] == CODE_MOTOR_CW))
    else $error("pedestrian request did not start the gate motor");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[8:5] <= 4'd9) && (m_axis_tdata[12:9] <= 4'd9)))
    else $error("countdown digit out of decimal range");

endmodule
